// ===== design/tcp_connection_fsm_macros.svh =====
// Assertion macros used by the back part of the connection state machine.
`ifndef TCP_CONNECTION_FSM_MACROS_SVH
`define TCP_CONNECTION_FSM_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TCPF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TCPF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcpf_pkg.sv =====
// Package with the types, codes and constants of the connection state machine.
package tcpf_pkg;

    localparam int TCPF_SEQ_BITS    = 32;
    localparam int TCPF_QUEUE_DEPTH = 4;

    localparam logic [31:0] TCPF_RESET_SEQ = 32'd100;
    localparam logic [31:0] TCPF_RESET_ACK = 32'd300;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_INITIAL_SEQ = 1'b0;
    localparam t_cfg_idx CFG_INITIAL_ACK = 1'b1;

    localparam logic [1:0] CMD_SEND  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    localparam logic [1:0] VIEW_OPEN   = 2'd1;
    localparam logic [1:0] VIEW_CLOSED = 2'd2;

    typedef enum logic [2:0] {
        K_ERR,
        K_SYN,
        K_SYNACK,
        K_ACK,
        K_FINACK,
        K_DELIVER,
        K_DELIVER_ACK,
        K_ACK_FINACK
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] seq;
        logic [31:0] ack_nr;
        logic [15:0] src_port;
        logic [15:0] dest_port;
        logic [3:0]  conn_state;
    } t_job;

    typedef struct packed {
        logic        to_upper;
        logic        syn;
        logic        ack;
        logic        fin;
        logic [31:0] seq;
        logic [31:0] ack_nr;
        logic [15:0] src_port;
        logic [15:0] dest_port;
        logic        error;
        logic        last;
        logic [3:0]  conn_state;
    } t_result;

endpackage

// ===== design/tcpf_front.sv =====
// Front part: accepts requests, updates connection state and numbers, emits jobs.
module tcpf_front
    import tcpf_pkg::*;
#(
    parameter int SEQ_BITS = TCPF_SEQ_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_push,
    input  logic        i_mode,
    input  logic [1:0]  i_app_command,
    input  logic [1:0]  i_app_status,
    input  logic        i_seg_syn,
    input  logic        i_seg_ack,
    input  logic        i_seg_fin,
    input  logic [31:0] i_seg_seq,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dest_port,
    input  logic        i_full,
    output logic        o_job_push,
    output t_job        o_job
);

    localparam int XW = (SEQ_BITS > 32) ? SEQ_BITS : 32;

    typedef enum logic [3:0] {
        S_CLOSED     = 4'd0,
        S_SYN_SENT   = 4'd1,
        S_SYN_RCVD   = 4'd2,
        S_ESTAB      = 4'd3,
        S_FIN_WAIT_1 = 4'd4,
        S_FIN_WAIT_2 = 4'd5,
        S_TIME_WAIT  = 4'd6,
        S_CLOSE_WAIT = 4'd7,
        S_LAST_ACK   = 4'd8
    } t_link_state;

    t_link_state         r_state, n_state;
    logic [SEQ_BITS-1:0] r_local_seq, n_local_seq;
    logic [SEQ_BITS-1:0] r_remote_ack, n_remote_ack;

    logic                w_accept;
    logic                w_has_job;
    t_kind               w_kind;
    logic [XW-1:0]       w_seg_seq_x;
    logic [XW-1:0]       w_cfg_x;
    logic [XW-1:0]       w_rst_seq_x;
    logic [XW-1:0]       w_rst_ack_x;
    logic [XW-1:0]       w_seq_out_x;
    logic [XW-1:0]       w_ack_out_x;
    logic [SEQ_BITS-1:0] w_next_ack;
    logic [SEQ_BITS-1:0] w_seq_inc;

    assign w_accept    = i_push && !i_full;
    assign w_seg_seq_x = XW'(i_seg_seq);
    assign w_cfg_x     = XW'(i_cfg_wdata);
    assign w_rst_seq_x = XW'(TCPF_RESET_SEQ);
    assign w_rst_ack_x = XW'(TCPF_RESET_ACK);
    assign w_next_ack  = w_seg_seq_x[SEQ_BITS-1:0] + SEQ_BITS'(1);
    assign w_seq_inc   = r_local_seq + SEQ_BITS'(1);

    always_comb begin
        n_state      = r_state;
        n_local_seq  = r_local_seq;
        n_remote_ack = r_remote_ack;
        w_kind       = K_ERR;
        w_has_job    = 1'b1;
        if (!i_mode) begin
            if (i_app_command == CMD_OPEN && i_app_status == VIEW_CLOSED
                    && r_state == S_CLOSED) begin
                w_kind  = K_SYN;
                n_state = S_SYN_SENT;
            end else if (i_app_command == CMD_CLOSE && i_app_status == VIEW_OPEN
                    && r_state == S_ESTAB) begin
                w_kind  = K_FINACK;
                n_state = S_FIN_WAIT_1;
            end else if (i_app_command == CMD_SEND && i_app_status == VIEW_OPEN
                    && r_state == S_ESTAB) begin
                w_kind = K_ACK;
            end
        end else begin
            case (r_state)
                S_CLOSED: begin
                    if (i_seg_syn) begin
                        n_local_seq  = r_remote_ack;
                        n_remote_ack = w_next_ack;
                        w_kind       = K_SYNACK;
                        n_state      = S_SYN_RCVD;
                    end
                end
                S_SYN_SENT: begin
                    if (i_seg_ack && i_seg_syn) begin
                        n_remote_ack = w_next_ack;
                        n_local_seq  = w_seq_inc;
                        w_kind       = K_DELIVER_ACK;
                        n_state      = S_ESTAB;
                    end
                end
                S_SYN_RCVD: begin
                    if (i_seg_ack) begin
                        w_has_job = 1'b0;
                        n_state   = S_ESTAB;
                    end
                end
                S_ESTAB: begin
                    n_remote_ack = w_next_ack;
                    n_local_seq  = w_seq_inc;
                    if (i_seg_fin && i_seg_ack) begin
                        w_kind  = K_ACK_FINACK;
                        n_state = S_LAST_ACK;
                    end else begin
                        w_kind = K_DELIVER;
                    end
                end
                S_FIN_WAIT_1: begin
                    if (i_seg_ack) begin
                        w_has_job    = 1'b0;
                        n_remote_ack = w_next_ack;
                        n_state      = S_FIN_WAIT_2;
                    end
                end
                S_FIN_WAIT_2: begin
                    if (i_seg_ack && i_seg_fin) begin
                        n_remote_ack = w_next_ack;
                        n_local_seq  = w_seq_inc;
                        w_kind       = K_ACK;
                        n_state      = S_CLOSED;
                    end
                end
                S_LAST_ACK: begin
                    if (i_seg_ack) begin
                        w_has_job = 1'b0;
                        n_state   = S_CLOSED;
                    end
                end
                default: begin
                    w_kind = K_ERR;
                end
            endcase
        end
    end

    assign w_seq_out_x = XW'(n_local_seq);
    assign w_ack_out_x = XW'(n_remote_ack);

    assign o_job_push       = w_accept && w_has_job;
    assign o_job.kind       = w_kind;
    assign o_job.seq        = w_seq_out_x[31:0];
    assign o_job.ack_nr     = w_ack_out_x[31:0];
    assign o_job.src_port   = i_src_port;
    assign o_job.dest_port  = i_dest_port;
    assign o_job.conn_state = n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLOSED;
            r_local_seq  <= w_rst_seq_x[SEQ_BITS-1:0];
            r_remote_ack <= w_rst_ack_x[SEQ_BITS-1:0];
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INITIAL_SEQ: r_local_seq  <= w_cfg_x[SEQ_BITS-1:0];
                CFG_INITIAL_ACK: r_remote_ack <= w_cfg_x[SEQ_BITS-1:0];
                default: begin
                    r_local_seq <= r_local_seq;
                end
            endcase
        end else if (w_accept) begin
            r_state      <= n_state;
            r_local_seq  <= n_local_seq;
            r_remote_ack <= n_remote_ack;
        end
    end

endmodule

// ===== design/tcpf_queue.sv =====
// Short job queue between the front and the back part.
module tcpf_queue
    import tcpf_pkg::*;
#(
    parameter int DEPTH = TCPF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_wr, w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== design/tcpf_back.sv =====
// Back part: expands each job into its results and holds them in the output register.
module tcpf_back
    import tcpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_job,
    input  logic    i_job_empty,
    output logic    o_job_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

`include "tcp_connection_fsm_macros.svh"

    logic    r_out_valid;
    logic    r_phase;
    t_result r_out;

    logic    w_load;
    logic    w_two;
    logic    w_last;
    t_result w_res;

    assign w_load = !r_out_valid || i_pop;
    assign w_two  = (i_job.kind == K_DELIVER_ACK) || (i_job.kind == K_ACK_FINACK);
    assign w_last = !w_two || r_phase;

    always_comb begin
        w_res            = '0;
        w_res.last       = w_last;
        w_res.conn_state = i_job.conn_state;
        case (i_job.kind)
            K_ERR: begin
                w_res.error = 1'b1;
            end
            K_SYN: begin
                w_res.syn       = 1'b1;
                w_res.seq       = i_job.seq;
                w_res.src_port  = i_job.src_port;
                w_res.dest_port = i_job.dest_port;
            end
            K_SYNACK: begin
                w_res.syn       = 1'b1;
                w_res.ack       = 1'b1;
                w_res.seq       = i_job.seq;
                w_res.ack_nr    = i_job.ack_nr;
                w_res.src_port  = i_job.src_port;
                w_res.dest_port = i_job.dest_port;
            end
            K_ACK: begin
                w_res.ack       = 1'b1;
                w_res.seq       = i_job.seq;
                w_res.ack_nr    = i_job.ack_nr;
                w_res.src_port  = i_job.src_port;
                w_res.dest_port = i_job.dest_port;
            end
            K_FINACK: begin
                w_res.ack       = 1'b1;
                w_res.fin       = 1'b1;
                w_res.seq       = i_job.seq;
                w_res.ack_nr    = i_job.ack_nr;
                w_res.src_port  = i_job.src_port;
                w_res.dest_port = i_job.dest_port;
            end
            K_DELIVER: begin
                w_res.to_upper  = 1'b1;
                w_res.src_port  = i_job.src_port;
                w_res.dest_port = i_job.dest_port;
            end
            K_DELIVER_ACK: begin
                w_res.to_upper  = !r_phase;
                w_res.ack       = r_phase;
                w_res.seq       = r_phase ? i_job.seq : '0;
                w_res.ack_nr    = r_phase ? i_job.ack_nr : '0;
                w_res.src_port  = i_job.src_port;
                w_res.dest_port = i_job.dest_port;
            end
            K_ACK_FINACK: begin
                w_res.ack       = 1'b1;
                w_res.fin       = r_phase;
                w_res.seq       = i_job.seq;
                w_res.ack_nr    = i_job.ack_nr;
                w_res.src_port  = r_phase ? '0 : i_job.src_port;
                w_res.dest_port = r_phase ? '0 : i_job.dest_port;
            end
            default: begin
                w_res.error = 1'b1;
            end
        endcase
    end

    assign o_job_pop = w_load && !i_job_empty && w_last;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= !i_job_empty;
            if (!i_job_empty) begin
                r_out   <= w_res;
                r_phase <= !w_last;
            end
        end
    end

    `TCPF_ASSERT_IMP(a_err_is_last, i_clk, i_rst_n, r_out_valid && r_out.error, r_out.last, "error result not marked last")
    `TCPF_ASSERT_IMP(a_upper_no_flags, i_clk, i_rst_n, r_out_valid && r_out.to_upper, !r_out.syn && !r_out.ack && !r_out.fin && !r_out.error, "delivery carries segment flags")
    `TCPF_ASSERT_IMP(a_phase_has_job, i_clk, i_rst_n, r_phase, !i_job_empty && r_out_valid && !r_out.last, "second result pending without its job")

endmodule

// ===== design/tcp_connection_fsm.sv =====
// Top level of the connection state machine: front part, job queue and back part.
// A request's job is registered in the job queue and then in the output register of the back part.
// Throughput: one request per cycle while the job queue is not full; a request with two
// results holds the back part for both of them, one result per cycle while the output is popped.
// The job queue lets requests keep coming while the output register waits to be popped.
// Reset (synchronous, active low) returns to closed with sequence 100 and ack 300, job queue empty.
module tcp_connection_fsm
    import tcpf_pkg::*;
#(
    parameter int SEQ_BITS    = TCPF_SEQ_BITS,
    parameter int QUEUE_DEPTH = TCPF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_mode,
    input  logic [1:0]  i_app_command,
    input  logic [1:0]  i_app_status,
    input  logic        i_seg_syn,
    input  logic        i_seg_ack,
    input  logic        i_seg_fin,
    input  logic [31:0] i_seg_seq,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dest_port,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_to_upper,
    output logic        o_out_syn,
    output logic        o_out_ack,
    output logic        o_out_fin,
    output logic [31:0] o_out_seq,
    output logic [31:0] o_out_ack_nr,
    output logic [15:0] o_out_src_port,
    output logic [15:0] o_out_dest_port,
    output logic        o_error,
    output logic        o_last,
    output logic [3:0]  o_conn_state
);

    logic    w_job_push;
    t_job    w_job_in;
    logic    w_job_pop;
    t_job    w_job_out;
    logic    w_job_empty;
    t_result w_result;

    tcpf_front #(
        .SEQ_BITS (SEQ_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (i_push),
        .i_mode        (i_mode),
        .i_app_command (i_app_command),
        .i_app_status  (i_app_status),
        .i_seg_syn     (i_seg_syn),
        .i_seg_ack     (i_seg_ack),
        .i_seg_fin     (i_seg_fin),
        .i_seg_seq     (i_seg_seq),
        .i_src_port    (i_src_port),
        .i_dest_port   (i_dest_port),
        .i_full        (o_full),
        .o_job_push    (w_job_push),
        .o_job         (w_job_in)
    );

    tcpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (o_full),
        .i_pop   (w_job_pop),
        .o_job   (w_job_out),
        .o_empty (w_job_empty)
    );

    tcpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_out),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (w_result)
    );

    assign o_to_upper      = w_result.to_upper;
    assign o_out_syn       = w_result.syn;
    assign o_out_ack       = w_result.ack;
    assign o_out_fin       = w_result.fin;
    assign o_out_seq       = w_result.seq;
    assign o_out_ack_nr    = w_result.ack_nr;
    assign o_out_src_port  = w_result.src_port;
    assign o_out_dest_port = w_result.dest_port;
    assign o_error         = w_result.error;
    assign o_last          = w_result.last;
    assign o_conn_state    = w_result.conn_state;

endmodule
